[rtl/q16d_pkg.sv]
// Shared types and constants for the signed Q16.16 divider.
// Used by the step stage, the core top level and its checker.
`default_nettype none

package q16d_pkg;

	localparam int WORD_W            = 32;
	localparam int FRACTION_BITS_DEF = 16;

	typedef struct packed {
		logic signed [WORD_W-1:0] dividend;
		logic signed [WORD_W-1:0] divisor;
	} operand_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] quotient;
		logic                     divide_by_zero;
	} result_t;

	// Payload of one restoring-division stage.
	typedef struct packed {
		logic              neg;   // operand signs differ
		logic              dbz;   // divisor was zero
		logic [WORD_W-1:0] md;    // divisor magnitude
		logic [WORD_W-1:0] num;   // dividend bits still to bring down, MSB first
		logic [WORD_W-1:0] rem;   // partial remainder, below md unless md is zero
		logic [WORD_W-1:0] quo;   // low quotient bits collected so far
	} stage_t;

endpackage

`default_nettype wire

[rtl/q16d_step.sv]
// One registered restoring-division step of the divider pipeline.
// Depends on q16d_pkg for stage_t and WORD_W.
`default_nettype none

module q16d_step (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              en,
	input  wire              prev_valid,
	input  q16d_pkg::stage_t prev_stage,
	output logic             valid,
	output q16d_pkg::stage_t stage
);
	import q16d_pkg::*;

	logic              valid_s1;
	stage_t            stage_s1;
	logic [WORD_W:0]   partial;
	logic [WORD_W-1:0] diff;
	logic              ge;
	stage_t            stage_nxt;

	// bring down the next dividend bit, trial-subtract the divisor
	always_comb begin
		partial = {prev_stage.rem, prev_stage.num[WORD_W-1]};
		diff    = partial[WORD_W-1:0] - prev_stage.md;
		ge      = (partial >= {1'b0, prev_stage.md});

		stage_nxt     = prev_stage;
		stage_nxt.num = {prev_stage.num[WORD_W-2:0], 1'b0};
		stage_nxt.rem = ge ? diff : partial[WORD_W-1:0];
		stage_nxt.quo = {prev_stage.quo[WORD_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= stage_nxt;
		end
	end

	assign valid = valid_s1;
	assign stage = stage_s1;

endmodule

`default_nettype wire

[rtl/q16_16_signed_divider_core.sv]
// Signed Q16.16 divider core: fully pipelined restoring divider.
// Depends on q16d_pkg and instantiates q16d_step once per quotient bit.
//
// Takes one operand transaction per clock while operand_stall is low and returns one
// result transaction per operand, in order. The result passes through the divider array:
// one restoring step (a 32-bit subtract and a 33-bit compare) per pipeline stage,
// with one stage in front that takes the operand magnitudes and one behind that
// applies the sign. The result is floor(|dividend| * 2^FRACTION_BITS / |divisor|)
// kept modulo 2^32, negated when the operand signs differ; a zero divisor gives
// quotient 0 with divide_by_zero set.
// While a finished result is stalled the whole pipeline holds and operand_stall is
// raised in the same cycle; nothing is dropped or repeated.
`default_nettype none

module q16_16_signed_divider_core #(
	parameter int FRACTION_BITS = q16d_pkg::FRACTION_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                operand_valid,
	output logic               operand_stall,
	input  q16d_pkg::operand_t operands,
	output logic               result_valid,
	input  wire                result_stall,
	output q16d_pkg::result_t  result
);
	import q16d_pkg::*;

	localparam int STEPS = WORD_W + FRACTION_BITS;

	logic              advance;

	// stage 1: magnitudes and sign
	logic              valid_s1;
	stage_t            stage_s1;
	stage_t            stage_in_nxt;

	// stage 2: chain of restoring steps
	logic [STEPS:0]    step_valid;
	stage_t            step_stage [STEPS+1];

	// stage 3: signed result register
	logic              valid_s3;
	result_t           res_s3;
	logic [WORD_W-1:0] quo_signed;

	// Hold every stage while the result register is full and stalled.
	assign advance       = !(valid_s3 && result_stall);
	assign operand_stall = !advance;

	// Take magnitudes; the most negative value maps to 2^31 as an unsigned word.
	always_comb begin
		stage_in_nxt.neg = operands.dividend[WORD_W-1] ^ operands.divisor[WORD_W-1];
		stage_in_nxt.dbz = (operands.divisor == '0);
		stage_in_nxt.md  = operands.divisor[WORD_W-1]
			? (WORD_W'(0) - WORD_W'(operands.divisor)) : WORD_W'(operands.divisor);
		stage_in_nxt.num = operands.dividend[WORD_W-1]
			? (WORD_W'(0) - WORD_W'(operands.dividend)) : WORD_W'(operands.dividend);
		stage_in_nxt.rem = '0;
		stage_in_nxt.quo = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= operand_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			stage_s1 <= stage_in_nxt;
		end
	end

	assign step_valid[0] = valid_s1;
	assign step_stage[0] = stage_s1;

	// One quotient bit per stage: 32 integer bits then the fraction bits.
	// Quotient bits above bit 31 shift out of the register, which wraps the magnitude.
	for (genvar g = 0; g < STEPS; g++) begin : g_step
		q16d_step u_step (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (advance),
			.prev_valid (step_valid[g]),
			.prev_stage (step_stage[g]),
			.valid      (step_valid[g+1]),
			.stage      (step_stage[g+1])
		);
	end

	// Apply the sign; a zero divisor forces the quotient to zero.
	always_comb begin
		quo_signed = step_stage[STEPS].neg
			? (WORD_W'(0) - step_stage[STEPS].quo) : step_stage[STEPS].quo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s3 <= step_valid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3.quotient       <= step_stage[STEPS].dbz ? '0 : quo_signed;
			res_s3.divide_by_zero <= step_stage[STEPS].dbz;
		end
	end

	assign result_valid = valid_s3;
	assign result       = res_s3;

endmodule

`default_nettype wire

[rtl/q16d_checker.sv]
// Port-level checker for the signed Q16.16 divider core, with its bind.
// Depends on q16d_pkg for the transaction types.
`default_nettype none

module q16d_checker (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                operand_valid,
	input  wire                operand_stall,
	input  q16d_pkg::operand_t operands,
	input  wire                result_valid,
	input  wire                result_stall,
	input  q16d_pkg::result_t  result
);
	import q16d_pkg::*;

	// A stalled result stays offered and unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or vanished");

	// Back-pressure only comes from a stalled, pending result.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		operand_stall == (result_valid && result_stall))
		else $error("operand stall does not follow the result stall");

	// A zero-divisor result carries a zero quotient.
	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.divide_by_zero |-> result.quotient == '0)
		else $error("divide-by-zero result with non-zero quotient");

	// With no result pending, an offered operand is never stalled.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !operand_stall)
		else $error("operands stalled with no result pending");

endmodule

bind q16_16_signed_divider_core q16d_checker u_q16d_checker (.*);

`default_nettype wire
